### rtl/core/credit_gated_packet_segmenter_assert.svh
// Assertion macros for the segmenter back end (cgps_back).
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CREDIT_GATED_PACKET_SEGMENTER_ASSERT_SVH
`define CREDIT_GATED_PACKET_SEGMENTER_ASSERT_SVH
`ifndef SYNTHESIS
`define CGPS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CGPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CGPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CGPS_ASSERT(label, cond, msg)
`define CGPS_ASSERT_IMPLY(label, ante, cons, msg)
`define CGPS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/core/cgps_pkg.sv
package cgps_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 1024;
    localparam int MAX_BURST_DEFAULT = 64;
    localparam int CMD_DEPTH = 2;

    localparam int FUNC_W = 2;
    localparam int ID_W = 16;
    localparam int LEN_W = 24;
    localparam int QOS_W = 3;
    localparam int SIZE_W = 15;
    localparam int CREDIT_W = 24;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MTU_RESET = 15'd4096;
    localparam logic [CREDIT_W-1:0] CREDIT_RESET = 24'd4194304;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX = 24'hFFFFFF;

    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREDIT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MTU,
        CFG_FLOW_CONTROL,
        CFG_QUEUE_MODE,
        CFG_BUFFER_SIZE
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_CREDIT,
        OP_POLL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [ID_W-1:0]   msg_id;
        logic [LEN_W-1:0]  msg_length;
        logic [QOS_W-1:0]  qos;
        logic [SIZE_W-1:0] credit_bytes;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic [ID_W-1:0]  msg_id;
        logic [LEN_W-1:0] msg_length;
        logic [QOS_W-1:0] qos;
        logic [LEN_W-1:0] offset;
    } q_entry_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   msg_id;
        logic [QOS_W-1:0]  qos;
        logic [LEN_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic              is_tail;
        logic              last;
        logic              more_pending;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_CHECK
    } back_state_t;

endpackage

### rtl/core/cgps_front.sv
module cgps_front
(
    input  logic                         start,
    input  logic [cgps_pkg::FUNC_W-1:0]  func,
    input  logic [cgps_pkg::ID_W-1:0]    msg_id,
    input  logic [cgps_pkg::LEN_W-1:0]   msg_length,
    input  logic [cgps_pkg::QOS_W-1:0]   qos,
    input  logic [cgps_pkg::SIZE_W-1:0]  credit_bytes,
    input  cgps_pkg::fifo_status_t       status,
    output logic                         busy,
    output logic                         push,
    output cgps_pkg::cmd_t               cmd
);

    cgps_pkg::cmd_op_t op;

    // Unused function codes behave as a poll.
    always_comb
    begin
        unique case (func)
            cgps_pkg::FUNC_SEND:   op = cgps_pkg::OP_SEND;
            cgps_pkg::FUNC_CREDIT: op = cgps_pkg::OP_CREDIT;
            cgps_pkg::FUNC_POLL:   op = cgps_pkg::OP_POLL;
            default:               op = cgps_pkg::OP_POLL;
        endcase
    end

    always_comb
    begin
        cmd.op           = op;
        cmd.msg_id       = msg_id;
        cmd.msg_length   = msg_length;
        cmd.qos          = qos;
        cmd.credit_bytes = credit_bytes;
    end

    assign busy = status.full;
    assign push = start && !status.full;

endmodule

### rtl/core/cgps_cmd_fifo.sv
module cgps_cmd_fifo #(
    parameter int DEPTH = cgps_pkg::CMD_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cgps_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output cgps_pkg::cmd_t         pop_cmd,
    output cgps_pkg::fifo_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cgps_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/core/cgps_back.sv
`include "credit_gated_packet_segmenter_assert.svh"

module cgps_back #(
    parameter int QUEUE_DEPTH = cgps_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int MAX_BURST   = cgps_pkg::MAX_BURST_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cgps_pkg::fifo_status_t         status,
    input  cgps_pkg::cmd_t                 cmd,
    output logic                           pop,
    input  logic                           wr_en,
    input  logic [cgps_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [cgps_pkg::CFG_W-1:0]     wr_data,
    output logic                           strobe,
    output cgps_pkg::result_t              result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int LEN_W = cgps_pkg::LEN_W;
    localparam int SIZE_W = cgps_pkg::SIZE_W;
    localparam int CREDIT_W = cgps_pkg::CREDIT_W;

    cgps_pkg::q_entry_t queue_mem [QUEUE_DEPTH];
    cgps_pkg::q_entry_t rd_entry_reg;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    cgps_pkg::q_entry_t mem_wdata;

    cgps_pkg::back_state_t state_reg;
    cgps_pkg::back_state_t state_next;
    logic [PTR_W-1:0]      head_ptr_reg;
    logic [PTR_W-1:0]      head_ptr_next;
    logic [PTR_W-1:0]      tail_ptr_reg;
    logic [PTR_W-1:0]      tail_ptr_next;
    logic [CNT_W-1:0]      entry_count_reg;
    logic [CNT_W-1:0]      entry_count_next;
    logic [CREDIT_W-1:0]   credit_reg;
    logic [CREDIT_W-1:0]   credit_next;
    logic [BURST_W-1:0]    burst_reg;
    logic [BURST_W-1:0]    burst_next;
    logic [LEN_W-1:0]      left_reg;
    logic [LEN_W-1:0]      left_next;
    cgps_pkg::result_t     pend_reg;
    cgps_pkg::result_t     pend_next;
    cgps_pkg::result_t     out_reg;
    cgps_pkg::result_t     out_next;
    logic                  strobe_reg;
    logic                  strobe_next;

    logic [SIZE_W-1:0] mtu_reg;
    logic              flow_control_reg;
    logic              queue_mode_reg;

    logic [SIZE_W-1:0]   mtu_eff;
    logic [LEN_W-1:0]    mtu_ext;
    logic [LEN_W-1:0]    size_full;
    logic                credit_ok;
    logic                tail_hit;
    logic [LEN_W-1:0]    new_offset;
    logic [CREDIT_W:0]   credit_sum;
    logic [CREDIT_W-1:0] credit_sat;
    logic                burst_full;
    cgps_pkg::q_entry_t  advanced_entry;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Packet sizing for the head entry; an mtu of zero acts as one byte.
    assign mtu_eff    = (mtu_reg == '0) ? SIZE_W'(1) : mtu_reg;
    assign mtu_ext    = {{(LEN_W - SIZE_W){1'b0}}, mtu_eff};
    assign size_full  = (left_reg < mtu_ext) ? left_reg : mtu_ext;
    assign credit_ok  = (size_full <= credit_reg);
    assign tail_hit   = (size_full == left_reg);
    assign new_offset = rd_entry_reg.offset + size_full;
    assign burst_full = (burst_reg == BURST_W'(MAX_BURST));

    assign credit_sum = {1'b0, credit_reg}
                      + {{(CREDIT_W - SIZE_W + 1){1'b0}}, cmd.credit_bytes};
    assign credit_sat = credit_sum[CREDIT_W] ? cgps_pkg::CREDIT_MAX
                                             : credit_sum[CREDIT_W-1:0];

    always_comb
    begin
        advanced_entry        = rd_entry_reg;
        advanced_entry.offset = new_offset;
    end

    always_comb
    begin
        state_next       = state_reg;
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        entry_count_next = entry_count_reg;
        credit_next      = credit_reg;
        burst_next       = burst_reg;
        left_next        = left_reg;
        pend_next        = pend_reg;
        out_next         = out_reg;
        strobe_next      = 1'b0;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = tail_ptr_reg;
        mem_wdata        = advanced_entry;

        unique case (state_reg)
            cgps_pkg::ST_IDLE:
            begin
                if (!status.empty)
                begin
                    pop        = 1'b1;
                    burst_next = '0;
                    unique case (cmd.op)
                        cgps_pkg::OP_SEND:
                        begin
                            if (entry_count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                strobe_next           = 1'b1;
                                out_next.kind         = cgps_pkg::KIND_REJECT;
                                out_next.msg_id       = cmd.msg_id;
                                out_next.qos          = cmd.qos;
                                out_next.offset       = '0;
                                out_next.size         = '0;
                                out_next.is_tail      = 1'b0;
                                out_next.last         = 1'b1;
                                out_next.more_pending = 1'b0;
                            end
                            else
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = tail_ptr_reg;
                                mem_wdata.msg_id     = cmd.msg_id;
                                mem_wdata.msg_length = cmd.msg_length;
                                mem_wdata.qos        = cmd.qos;
                                mem_wdata.offset     = '0;
                                tail_ptr_next        = next_slot(tail_ptr_reg);
                                entry_count_next     = entry_count_reg + 1'b1;
                                state_next           = cgps_pkg::ST_LOAD;
                            end
                        end
                        cgps_pkg::OP_CREDIT:
                        begin
                            credit_next = credit_sat;
                            state_next  = cgps_pkg::ST_LOAD;
                        end
                        default:
                        begin
                            state_next = cgps_pkg::ST_LOAD;
                        end
                    endcase
                end
            end
            cgps_pkg::ST_LOAD:
            begin
                // The head entry is read this cycle; an empty queue ends the item.
                if (entry_count_reg == '0)
                begin
                    strobe_next           = (burst_reg != '0);
                    out_next              = pend_reg;
                    out_next.last         = 1'b1;
                    out_next.more_pending = 1'b0;
                    state_next            = cgps_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cgps_pkg::ST_CALC;
                end
            end
            cgps_pkg::ST_CALC:
            begin
                left_next  = rd_entry_reg.msg_length - rd_entry_reg.offset;
                state_next = cgps_pkg::ST_CHECK;
            end
            cgps_pkg::ST_CHECK:
            begin
                if (credit_ok && !burst_full)
                begin
                    // A new packet goes into the pending slot; the one before it
                    // leaves now, since it is known not to be the last.
                    strobe_next            = (burst_reg != '0);
                    out_next               = pend_reg;
                    pend_next.kind         = cgps_pkg::KIND_PACKET;
                    pend_next.msg_id       = rd_entry_reg.msg_id;
                    pend_next.qos          = rd_entry_reg.qos;
                    pend_next.offset       = rd_entry_reg.offset;
                    pend_next.size         = size_full[SIZE_W-1:0];
                    pend_next.is_tail      = tail_hit;
                    pend_next.last         = 1'b0;
                    pend_next.more_pending = 1'b0;
                    burst_next             = burst_reg + 1'b1;
                    if (flow_control_reg)
                    begin
                        credit_next = credit_reg - size_full;
                    end
                    if (tail_hit)
                    begin
                        head_ptr_next    = next_slot(head_ptr_reg);
                        entry_count_next = entry_count_reg - 1'b1;
                    end
                    else if (queue_mode_reg)
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = tail_ptr_reg;
                        tail_ptr_next = next_slot(tail_ptr_reg);
                        head_ptr_next = next_slot(head_ptr_reg);
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ptr_reg;
                    end
                    state_next = cgps_pkg::ST_LOAD;
                end
                else
                begin
                    strobe_next           = (burst_reg != '0);
                    out_next              = pend_reg;
                    out_next.last         = 1'b1;
                    out_next.more_pending = credit_ok;
                    state_next            = cgps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cgps_pkg::ST_IDLE;
            end
        endcase

        if (wr_en && (cgps_pkg::cfg_index_t'(wr_index) == cgps_pkg::CFG_BUFFER_SIZE))
        begin
            credit_next = wr_data[CREDIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cgps_pkg::ST_IDLE;
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            entry_count_reg <= '0;
            credit_reg      <= cgps_pkg::CREDIT_RESET;
            burst_reg       <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            entry_count_reg <= entry_count_next;
            credit_reg      <= credit_next;
            burst_reg       <= burst_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg          <= cgps_pkg::MTU_RESET;
            flow_control_reg <= 1'b1;
            queue_mode_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cgps_pkg::cfg_index_t'(wr_index))
                cgps_pkg::CFG_MTU:          mtu_reg <= wr_data[SIZE_W-1:0];
                cgps_pkg::CFG_FLOW_CONTROL: flow_control_reg <= wr_data[0];
                cgps_pkg::CFG_QUEUE_MODE:   queue_mode_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // The head entry is read every cycle; writes never land in the load cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= queue_mem[head_ptr_reg];
    end

    assign strobe = strobe_reg;
    assign result = out_reg;

    `CGPS_ASSERT(a_count_bound, entry_count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `CGPS_ASSERT_IMPLY(a_empty_ptrs, entry_count_reg == '0, head_ptr_reg == tail_ptr_reg, "empty queue with pointers apart")
    `CGPS_ASSERT_IMPLY(a_more_on_last, strobe_reg && out_reg.more_pending, out_reg.last, "more pending flag on a non-final item")
    `CGPS_ASSERT_NEXT(a_quiet_after_last, strobe_reg && out_reg.last, !strobe_reg || (out_reg.kind == cgps_pkg::KIND_REJECT), "packet directly after a final item")

endmodule

### rtl/core/credit_gated_packet_segmenter.sv
// Accepts send, credit-return and poll items on start while busy is low; busy rises only
// when the two-entry command queue is full. The back end applies each command in its idle
// state and then makes each packet in steps (read of the message queue memory, remainder
// subtract, size and credit compare); a burst gives at most MAX_BURST results. Each result
// appears on strobe for exactly one cycle and cannot be held off, so the receiver must take
// every strobe. A rejected send gives a single result in the cycle after the back end picks
// it up.
module credit_gated_packet_segmenter #(
    parameter int QUEUE_DEPTH = cgps_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int MAX_BURST   = cgps_pkg::MAX_BURST_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [cgps_pkg::FUNC_W-1:0]    func,
    input  logic [cgps_pkg::ID_W-1:0]      msg_id,
    input  logic [cgps_pkg::LEN_W-1:0]     msg_length,
    input  logic [cgps_pkg::QOS_W-1:0]     qos,
    input  logic [cgps_pkg::SIZE_W-1:0]    credit_bytes,
    input  logic                           wr_en,
    input  logic [cgps_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [cgps_pkg::CFG_W-1:0]     wr_data,
    output logic                           strobe,
    output logic                           kind,
    output logic [cgps_pkg::ID_W-1:0]      pkt_msg_id,
    output logic [cgps_pkg::QOS_W-1:0]     pkt_qos,
    output logic [cgps_pkg::LEN_W-1:0]     offset,
    output logic [cgps_pkg::SIZE_W-1:0]    pkt_size,
    output logic                           is_tail,
    output logic                           last,
    output logic                           more_pending
);

    cgps_pkg::fifo_status_t status;
    cgps_pkg::cmd_t         push_cmd;
    cgps_pkg::cmd_t         pop_cmd;
    cgps_pkg::result_t      result;
    logic                   push;
    logic                   pop;

    cgps_front u_front
    (
        .start        (start),
        .func         (func),
        .msg_id       (msg_id),
        .msg_length   (msg_length),
        .qos          (qos),
        .credit_bytes (credit_bytes),
        .status       (status),
        .busy         (busy),
        .push         (push),
        .cmd          (push_cmd)
    );

    cgps_cmd_fifo #(
        .DEPTH (cgps_pkg::CMD_DEPTH)
    ) u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (status)
    );

    cgps_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (pop_cmd),
        .pop      (pop),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .strobe   (strobe),
        .result   (result)
    );

    assign kind         = result.kind;
    assign pkt_msg_id   = result.msg_id;
    assign pkt_qos      = result.qos;
    assign offset       = result.offset;
    assign pkt_size     = result.size;
    assign is_tail      = result.is_tail;
    assign last         = result.last;
    assign more_pending = result.more_pending;

endmodule
